// File: hdl/s7f_pkg.sv
// Types, constants and the tap-sum function of the separable 7-tap image filter.
// No dependencies; the other files refer to this package by scoped names or import it.
package s7f_pkg;

  localparam int unsigned TAPS        = 7;
  localparam int unsigned STORED_ROWS = TAPS - 1;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned SHIFT_BITS  = 8;
  localparam int unsigned LS_W        = STORED_ROWS * PIX_W;
  localparam int unsigned FW_W        = 12;
  localparam int unsigned FH_W        = 13;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned CFG_DW      = 13;
  localparam int unsigned MAX_HEIGHT  = 4096;

  localparam logic [FW_W-1:0] FW_RESET = 12'd2000;
  localparam logic [FH_W-1:0] FH_RESET = 13'd1500;

  typedef logic [TAPS-1:0][PIX_W-1:0] tap_vec_t;

  localparam tap_vec_t COEF = {8'd2, 8'd15, 8'd62, 8'd98, 8'd62, 8'd15, 8'd2};

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  function automatic logic [PIX_W-1:0] tap_sum(tap_vec_t v);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < TAPS; i++) begin
      s = s + SUM_W'(COEF[i]) * SUM_W'(v[i]);
    end
    return s[SHIFT_BITS +: PIX_W];
  endfunction

endpackage

// File: hdl/s7f_pix_in_if.sv
// Input channel of the filter: valid/ready handshake carrying one pixel item.
// Depends on s7f_pkg for the pixel width.
interface s7f_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [s7f_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

// File: hdl/s7f_pix_out_if.sv
// Output channel of the filter: valid/ready handshake carrying one result item.
// Depends on s7f_pkg for the pixel width.
interface s7f_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [s7f_pkg::PIX_W-1:0] pixel_out;
  logic                      frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// File: hdl/s7f_line_ram.sv
// Line store RAM: one write port and one read port, read data registered.
// Stand-alone; holds the six stored rows of one column in each word.
module s7f_line_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/separable_7tap_image_filter.sv
// Separable 7-tap image filter: pixels pass stage 1, stage 2 and the output register.
// Throughput 1 pixel per cycle while the skid is empty; one line RAM column word
// per pixel is read at accept and written back in stage 1.
// Reset clears counters, window, pipeline and output valid; registers go to 2000/1500.
// The line RAM is not cleared; entries are written by the first six rows of a frame.
// Depends on s7f_pkg, s7f_pix_in_if, s7f_pix_out_if and s7f_line_ram.
module separable_7tap_image_filter #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  s7f_pix_in_if.sink                 pix_i,
  s7f_pix_out_if.source              res_o,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [s7f_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (WW > s7f_pkg::FW_W) ? WW : s7f_pkg::FW_W;
  localparam int unsigned PW = s7f_pkg::PIX_W;

  logic [s7f_pkg::FW_W-1:0] fw_q, fw_d;
  logic [s7f_pkg::FH_W-1:0] fh_q, fh_d;
  logic [AW-1:0]            x_q, x_d;
  logic [s7f_pkg::ROW_W-1:0] y_q, y_d;
  s7f_pkg::tap_vec_t        win_q, win_d;

  logic [CW-1:0]            fw_ext, w_clamp;
  logic [WW-1:0]            w;
  logic [s7f_pkg::FH_W-1:0] ht;
  logic [WW-1:0]            x_ext, x_inc;
  logic [s7f_pkg::FH_W-1:0] y_ext, y_inc;
  logic                     advance, in_acc, cfg_hit;
  logic                     mem_hit, emit, last;
  logic [AW-1:0]            hx;

  logic                     s1_valid_q, s1_hit_q, s1_emit_q, s1_last_q;
  logic [AW-1:0]            s1_addr_q;
  logic [s7f_pkg::LS_W-1:0] rd_data;
  logic [PW-1:0]            h_val;
  logic                     ram_wr;

  logic                     s2_valid_q, s2_last_q;
  s7f_pkg::tap_vec_t        s2_col_q;
  logic [PW-1:0]            v_val;

  logic                     out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [PW-1:0]            out_pix_q, out_pix_d;
  logic                     sk_valid_q, sk_valid_d, sk_last_q, sk_last_d;
  logic [PW-1:0]            sk_pix_q, sk_pix_d;
  logic                     push, pop;

  // frame size clamp
  always_comb begin
    fw_ext = CW'(fw_q);
    if (fw_ext < CW'(s7f_pkg::TAPS)) begin
      w_clamp = CW'(s7f_pkg::TAPS);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      w_clamp = CW'(MAX_WIDTH);
    end else begin
      w_clamp = fw_ext;
    end
    w = w_clamp[WW-1:0];
    if (fh_q < s7f_pkg::FH_W'(s7f_pkg::TAPS)) begin
      ht = s7f_pkg::FH_W'(s7f_pkg::TAPS);
    end else if (fh_q > s7f_pkg::FH_W'(s7f_pkg::MAX_HEIGHT)) begin
      ht = s7f_pkg::FH_W'(s7f_pkg::MAX_HEIGHT);
    end else begin
      ht = fh_q;
    end
  end

  assign advance     = !sk_valid_q;
  assign pix_i.ready = advance;
  assign in_acc      = pix_i.valid && advance;

  assign x_ext   = WW'(x_q);
  assign x_inc   = x_ext + WW'(1);
  assign y_ext   = s7f_pkg::FH_W'(y_q);
  assign y_inc   = y_ext + s7f_pkg::FH_W'(1);
  assign mem_hit = (x_ext >= WW'(s7f_pkg::STORED_ROWS)) && (x_ext < w);
  assign emit    = y_ext >= s7f_pkg::FH_W'(s7f_pkg::STORED_ROWS);
  assign last    = (x_inc == w) && (y_inc == ht);
  assign hx      = x_q - AW'(s7f_pkg::STORED_ROWS);

  // configuration and frame position
  always_comb begin
    fw_d    = fw_q;
    fh_d    = fh_q;
    x_d     = x_q;
    y_d     = y_q;
    win_d   = win_q;
    cfg_hit = 1'b0;
    if (in_acc) begin
      win_d = {pix_i.pixel_in, win_q[s7f_pkg::TAPS-1:1]};
      if (x_inc >= w) begin
        x_d = '0;
        y_d = (y_inc >= ht) ? '0 : y_inc[s7f_pkg::ROW_W-1:0];
      end else begin
        x_d = x_inc[AW-1:0];
      end
    end
    if (cfg_we_i) begin
      unique case (s7f_pkg::cfg_reg_e'(cfg_idx_i))
        s7f_pkg::REG_FRAME_WIDTH: begin
          fw_d    = cfg_data_i[s7f_pkg::FW_W-1:0];
          cfg_hit = 1'b1;
        end
        s7f_pkg::REG_FRAME_HEIGHT: begin
          fh_d    = cfg_data_i[s7f_pkg::FH_W-1:0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    if (cfg_hit) begin
      x_d = '0;
      y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= s7f_pkg::FW_RESET;
      fh_q  <= s7f_pkg::FH_RESET;
      x_q   <= '0;
      y_q   <= '0;
      win_q <= '0;
    end else begin
      fw_q  <= fw_d;
      fh_q  <= fh_d;
      x_q   <= x_d;
      y_q   <= y_d;
      win_q <= win_d;
    end
  end

  // stage 1: line RAM read data arrives, horizontal sum, write back
  s7f_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (s7f_pkg::LS_W)
  ) u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc && mem_hit),
    .rd_addr_i (hx),
    .rd_data_o (rd_data),
    .wr_en_i   (ram_wr),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({h_val, rd_data[s7f_pkg::LS_W-1:PW]})
  );

  assign h_val  = s7f_pkg::tap_sum(win_q);
  assign ram_wr = advance && s1_valid_q && s1_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q && s1_hit_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_hit_q  <= mem_hit;
      s1_emit_q <= emit;
      s1_last_q <= last;
      s1_addr_q <= hx;
      s2_last_q <= s1_last_q;
      s2_col_q  <= {h_val, rd_data};
    end
  end

  // stage 2: vertical sum into output register with skid
  assign v_val = s7f_pkg::tap_sum(s2_col_q);
  assign push  = advance && s2_valid_q;
  assign pop   = out_valid_q && res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_last_d  = out_last_q;
    sk_valid_d  = sk_valid_q;
    sk_pix_d    = sk_pix_q;
    sk_last_d   = sk_last_q;
    if (pop) begin
      if (sk_valid_q) begin
        out_pix_d  = sk_pix_q;
        out_last_d = sk_last_q;
        sk_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (push) begin
      if (out_valid_q && !pop) begin
        sk_valid_d = 1'b1;
        sk_pix_d   = v_val;
        sk_last_d  = s2_last_q;
      end else begin
        out_valid_d = 1'b1;
        out_pix_d   = v_val;
        out_last_d  = s2_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q  <= out_pix_d;
    out_last_q <= out_last_d;
    sk_pix_q   <= sk_pix_d;
    sk_last_q  <= sk_last_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.pixel_out  = out_pix_q;
  assign res_o.frame_last = out_last_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid holds an item while output register is empty");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_ext < w)
    else $error("column counter outside frame width");

  a_hit_reaches_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mem_hit) |=> (s1_valid_q && s1_hit_q))
    else $error("line RAM read lost before write back");

  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_wr && in_acc && mem_hit) |-> (s1_addr_q != hx))
    else $error("line RAM read and write back hit the same column");

endmodule

// File: tb/s7f_filter_checker.sv
// Scoreboard of the separable 7-tap image filter: mirrors the filter from the accepted
// pixel items and register writes, and checks each result item in order.
// Depends on s7f_pkg, s7f_pix_in_if and s7f_pix_out_if.
module s7f_filter_checker #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  s7f_pix_in_if                      pix_mon,
  s7f_pix_out_if                     res_mon,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [s7f_pkg::CFG_DW-1:0] cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o,
  output int unsigned                pixel_count_o,
  output int unsigned                result_count_o,
  output int unsigned                frame_count_o
);
  import s7f_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } filt_pix_t;

  typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;

  localparam int unsigned KERNEL [TAPS] = '{2, 15, 62, 98, 62, 15, 2};

  taps_t             row_taps;
  logic [PIX_W-1:0]  line_buf [STORED_ROWS][MAX_WIDTH];
  logic [FW_W-1:0]   width_reg;
  logic [FH_W-1:0]   height_reg;
  int unsigned       col_pos;
  int unsigned       row_pos;
  filt_pix_t         filtered_q [$];
  int unsigned       n_fail;
  int unsigned       n_pix;
  int unsigned       n_res;
  int unsigned       n_frames;

  function automatic logic [PIX_W-1:0] weighted7(taps_t v);
    int unsigned acc;
    acc = 0;
    for (int i = 0; i < TAPS; i++) begin
      acc += KERNEL[i] * v[i];
    end
    return PIX_W'(acc >> SHIFT_BITS);
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < TAPS) return TAPS;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic filter_pixel(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned hx;
    taps_t       column;
    filt_pix_t   item;
    for (int i = 0; i < TAPS - 1; i++) begin
      row_taps[i] = row_taps[i + 1];
    end
    row_taps[TAPS-1] = px;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (col_pos >= TAPS - 1 && col_pos < w) begin
      hx = (col_pos - (TAPS - 1)) % MAX_WIDTH;
      for (int i = 0; i < STORED_ROWS; i++) begin
        column[i] = line_buf[i][hx];
      end
      column[TAPS-1] = weighted7(row_taps);
      for (int i = 0; i < STORED_ROWS; i++) begin
        line_buf[i][hx] = column[i + 1];
      end
      if (row_pos >= TAPS - 1) begin
        item.pixel = weighted7(column);
        item.last  = (col_pos == w - 1) && (row_pos == h - 1);
        filtered_q.push_back(item);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic note_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("[%0t] result %0d: %s", $realtime, n_res, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : p_score
    filt_pix_t want;
    if (!rst_ni) begin
      row_taps   = '0;
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      col_pos    = 0;
      row_pos    = 0;
      for (int r = 0; r < STORED_ROWS; r++) begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
          line_buf[r][c] = '0;
        end
      end
      filtered_q.delete();
      n_fail   = 0;
      n_pix    = 0;
      n_res    = 0;
      n_frames = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (filtered_q.size() == 0) begin
          note_failure($sformatf("unexpected item pixel_out %0d frame_last %0b",
                                 res_mon.pixel_out, res_mon.frame_last));
        end else begin
          want = filtered_q.pop_front();
          if (res_mon.pixel_out !== want.pixel || res_mon.frame_last !== want.last) begin
            note_failure($sformatf("expected pixel_out %0d frame_last %0b, got %0d %0b",
                                   want.pixel, want.last, res_mon.pixel_out,
                                   res_mon.frame_last));
          end
        end
        if (res_mon.frame_last === 1'b1) n_frames++;
        n_res++;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FRAME_WIDTH) begin
          width_reg = cfg_data_i[FW_W-1:0];
        end else begin
          height_reg = cfg_data_i[FH_W-1:0];
        end
        col_pos = 0;
        row_pos = 0;
      end
      if (pix_mon.valid && pix_mon.ready) begin
        filter_pixel(pix_mon.pixel_in);
        n_pix++;
      end
    end
    fail_count_o   <= n_fail;
    pending_o      <= filtered_q.size();
    pixel_count_o  <= n_pix;
    result_count_o <= n_res;
    frame_count_o  <= n_frames;
  end

endmodule

// File: tb/tb_separable_7tap_image_filter.sv
// Testbench top of the separable 7-tap image filter: clock, reset, pixel stimulus,
// register writes and output backpressure; the verdict comes from s7f_filter_checker.
// Depends on s7f_pkg, both channel interfaces, the filter and the checker.
module tb_separable_7tap_image_filter;
  import s7f_pkg::*;

  localparam int unsigned MAX_W       = 2048;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned RAND_ITEMS  = 50;

  typedef enum int unsigned {
    PAT_RANDOM,
    PAT_EXTREME,
    PAT_ONES,
    PAT_ZEROS,
    PAT_ALTERNATE
  } pix_pattern_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_idx = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pixel_count;
  int unsigned result_count;
  int unsigned frame_count;
  int unsigned stall_cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_len = 0;
  int unsigned sent = 0;

  s7f_pix_in_if  pix_if ();
  s7f_pix_out_if res_if ();

  separable_7tap_image_filter #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_if),
    .res_o     (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  s7f_filter_checker #(
    .MAX_WIDTH(MAX_W)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_mon       (pix_if),
    .res_mon       (res_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .pixel_count_o (pixel_count),
    .result_count_o(result_count),
    .frame_count_o (frame_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles, %0d results outstanding",
               $realtime, stall_cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : p_receiver
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel(pix_pattern_e pat, int unsigned idx);
    case (pat)
      PAT_EXTREME:   return $urandom_range(1) ? 8'hFF : 8'h00;
      PAT_ONES:      return 8'hFF;
      PAT_ZEROS:     return 8'h00;
      PAT_ALTERNATE: return idx[0] ? 8'hFF : 8'h00;
      default:       return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] width_code(int unsigned eff);
    logic [CFG_DW-1:0] code;
    // bit 12 lies outside the width register
    code = {1'($urandom_range(1)), 12'(eff)};
    if (eff == TAPS && $urandom_range(1)) code[FW_W-1:0] = FW_W'($urandom_range(TAPS - 1));
    return code;
  endfunction

  function automatic logic [CFG_DW-1:0] height_code(int unsigned eff);
    if (eff == TAPS && $urandom_range(1)) return CFG_DW'($urandom_range(TAPS - 1));
    return CFG_DW'(eff);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= px;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
  endtask

  task automatic send_run(input int unsigned n, input pix_pattern_e pat);
    for (int unsigned i = 0; i < n; i++) begin
      send_pixel(pick_pixel(pat, i));
    end
    sent += n;
  endtask

  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic do_w, input logic [CFG_DW-1:0] w_code,
                           input logic do_h, input logic [CFG_DW-1:0] h_code);
    settle();
    if (do_w) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_FRAME_WIDTH;
      cfg_data <= w_code;
      @(posedge clk_i);
    end
    if (do_h) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_FRAME_HEIGHT;
      cfg_data <= h_code;
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : p_stimulus
    int unsigned  cur_w;
    int unsigned  cur_h;
    int unsigned  new_w;
    int unsigned  new_h;
    int unsigned  n;
    int unsigned  budget;
    logic         at_start;
    logic         do_w;
    logic         do_h;
    pix_pattern_e pat;
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry, then restart into the smallest frame by clamped codes
    send_run(10, PAT_RANDOM);
    configure(1'b1, 13'd3, 1'b1, 13'd0);
    send_run(TAPS * TAPS, PAT_ONES);
    send_run(TAPS * TAPS, PAT_ALTERNATE);
    cur_w    = TAPS;
    cur_h    = TAPS;
    at_start = 1'b1;

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct <= 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct <= 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      budget = sent + RAND_ITEMS;
      while (sent < budget) begin
        new_w = $urandom_range(TAPS, 12);
        new_h = $urandom_range(TAPS, 9);
        do_w  = (new_w != cur_w) || $urandom_range(1);
        do_h  = (new_h != cur_h) || $urandom_range(1) || (!at_start && !do_w);
        if (do_w || do_h) configure(do_w, width_code(new_w), do_h, height_code(new_h));
        cur_w = new_w;
        cur_h = new_h;
        pat   = ($urandom_range(3) != 0) ? PAT_RANDOM
                                         : pix_pattern_e'($urandom_range(PAT_ALTERNATE));
        // drop out mid-frame now and then; the next write restarts the frame
        if ($urandom_range(9) == 0) begin
          n        = $urandom_range(1, cur_w * cur_h - 1);
          at_start = 1'b0;
        end else begin
          n        = cur_w * cur_h;
          at_start = 1'b1;
        end
        send_run(n, pat);
      end
    end

    // hold the receiver off at the start of a 12x9 frame; the filter then stalls its input
    configure(1'b1, 13'd12, 1'b1, 13'd9);
    hold_len <= 300;
    hold_req <= hold_req + 1;
    send_run(12 * 9, PAT_RANDOM);

    configure(1'b1, 13'h0FFF, 1'b1, 13'd7);
    send_run(40, PAT_RANDOM);
    configure(1'b1, 13'h1007, 1'b1, 13'h1FFF);
    send_run(TAPS * TAPS, PAT_RANDOM);
    send_run(9, PAT_EXTREME);

    settle();
    repeat (10) @(posedge clk_i);
    $display("run: %0d pixels in, %0d filtered pixels checked, %0d frame ends seen",
             pixel_count, result_count, frame_count);
    $display("run: frames from 7x7 to 12x9, clamped and masked width and height codes,");
    $display("     mid-frame restarts, three idle mixes and a long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/s7f_pkg.sv
hdl/s7f_pix_in_if.sv
hdl/s7f_pix_out_if.sv
hdl/s7f_line_ram.sv
hdl/separable_7tap_image_filter.sv
tb/s7f_filter_checker.sv
tb/tb_separable_7tap_image_filter.sv
